// ===== rtl/core/qsel_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// qsel_pkg
// Shared widths and operation, axis and status codes for the axis-keyed quickselect block.
// ============================================================================
package qsel_pkg;

    localparam int IDX_W = 10;   // slot, rank and range fields
    localparam int POS_W = 12;   // signed scan position, from minus one up to one past the top slot
    localparam int KEY_W = 32;   // key port width
    localparam int IN_COORD_W = 32;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SELECT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

// ===== rtl/core/qsel_store.sv =====
`timescale 1ns / 1ps
// ============================================================================
// qsel_store
// Permutation memory and packed coordinate memory, one write and one
// registered read port each.
// ============================================================================
module qsel_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int SW    = 32
) (
    input  logic              clk,
    input  logic              p_we,
    input  logic [AW-1:0]     p_waddr,
    input  logic [AW-1:0]     p_wdata,
    input  logic [AW-1:0]     p_raddr,
    output logic [AW-1:0]     p_q,
    input  logic              c_we,
    input  logic [AW-1:0]     c_waddr,
    input  logic [3*SW-1:0]   c_wdata,
    input  logic [AW-1:0]     c_raddr,
    output logic [3*SW-1:0]   c_q
);

    logic [AW-1:0]   perm_mem  [DEPTH];
    logic [3*SW-1:0] coord_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            perm_mem[p_waddr] <= p_wdata;
        end
        p_q <= perm_mem[p_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            coord_mem[c_waddr] <= c_wdata;
        end
        c_q <= coord_mem[c_raddr];
    end

endmodule

// ===== rtl/core/quickselect_partition_by_axis_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// quickselect_partition_by_axis_top
// Particle coordinate store with Hoare quickselect over a permutation.
// ============================================================================
// A write or an error answers from the output word loaded when it is taken;
// a read first passes S_RD1 and S_RD2. Writes take one word per cycle while
// the output drains; no input is taken while a read or select is in work.
// Select steps, each set by the single read port of the permutation memory:
// scan S_SI, S_SI1, S_SI2 (or S_SJ*), swap S_W0 to S_W3, pass S_OUT, S_O*, S_F*.
// Reset clears the sequencer state and the output valid flag; memory contents are
// undefined until written, and no clearing pass runs.
// ============================================================================
module quickselect_partition_by_axis_top #(
    parameter int MAX_PARTICLES = 1024,
    parameter int COORD_BITS    = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic [qsel_pkg::IDX_W-1:0]        slot,
    input  logic signed [qsel_pkg::IN_COORD_W-1:0] coord_x,
    input  logic signed [qsel_pkg::IN_COORD_W-1:0] coord_y,
    input  logic signed [qsel_pkg::IN_COORD_W-1:0] coord_z,
    input  logic [1:0]                        axis,
    input  logic [qsel_pkg::IDX_W-1:0]        rank,
    input  logic [qsel_pkg::IDX_W-1:0]        range_low,
    input  logic [qsel_pkg::IDX_W-1:0]        range_high,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [qsel_pkg::IDX_W-1:0]        particle,
    output logic signed [qsel_pkg::KEY_W-1:0] key,
    output logic                              status
);

    // Only slots reachable through the 10-bit ports need storage.
    localparam int SLOTS = 1 << qsel_pkg::IDX_W;
    localparam int DEPTH = (MAX_PARTICLES < SLOTS) ? MAX_PARTICLES : SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Stored coordinate width: the input is never wider than 32 bits.
    localparam int SW    = (COORD_BITS < qsel_pkg::IN_COORD_W) ? COORD_BITS
                                                               : qsel_pkg::IN_COORD_W;
    localparam int PW    = qsel_pkg::POS_W;

    // Sequencer states. The naming follows the quickselect phases:
    // O* set up the pivot, SI*/SJ* are the two inward scans, W* the swap
    // inside the scan loop, F* the closing rotation that narrows the range.
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD1  = 5'd1;
    localparam logic [4:0] S_RD2  = 5'd2;
    localparam logic [4:0] S_OUT  = 5'd3;
    localparam logic [4:0] S_O1   = 5'd4;
    localparam logic [4:0] S_O2   = 5'd5;
    localparam logic [4:0] S_O3   = 5'd6;
    localparam logic [4:0] S_SI   = 5'd7;
    localparam logic [4:0] S_SI1  = 5'd8;
    localparam logic [4:0] S_SI2  = 5'd9;
    localparam logic [4:0] S_SJ   = 5'd10;
    localparam logic [4:0] S_SJ1  = 5'd11;
    localparam logic [4:0] S_SJ2  = 5'd12;
    localparam logic [4:0] S_W0   = 5'd13;
    localparam logic [4:0] S_W1   = 5'd14;
    localparam logic [4:0] S_W2   = 5'd15;
    localparam logic [4:0] S_W3   = 5'd16;
    localparam logic [4:0] S_F0   = 5'd17;
    localparam logic [4:0] S_F1   = 5'd18;
    localparam logic [4:0] S_F2   = 5'd19;
    localparam logic [4:0] S_F3   = 5'd20;
    localparam logic [4:0] S_F4   = 5'd21;

    logic [4:0]             state_reg, state_next;
    logic signed [PW-1:0]   k_reg, k_next;
    logic signed [PW-1:0]   l_reg, l_next;
    logic signed [PW-1:0]   r_reg, r_next;
    logic signed [PW-1:0]   i_reg, i_next;
    logic signed [PW-1:0]   j_reg, j_next;
    logic signed [SW-1:0]   v_reg, v_next;
    logic [AW-1:0]          pk_reg, pk_next;
    logic [AW-1:0]          t_reg, t_next;
    logic [1:0]             axis_reg, axis_next;

    logic                   out_valid_reg, out_valid_next;
    logic [qsel_pkg::IDX_W-1:0]        particle_reg, particle_next;
    logic signed [qsel_pkg::KEY_W-1:0] key_reg, key_next;
    logic                   status_reg, status_next;

    // Memory ports.
    logic                   p_we;
    logic [AW-1:0]          p_waddr, p_wdata, p_raddr, p_q;
    logic                   c_we;
    logic [AW-1:0]          c_waddr, c_raddr;
    logic [3*SW-1:0]        c_wdata, c_q;

    logic                   accept;
    logic                   out_free;
    logic                   slot_ok, axis_ok, sel_ok;
    logic signed [SW-1:0]   key_sel;
    logic signed [PW-1:0]   i_inc, j_dec;
    logic signed [PW-1:0]   rank_pos, low_pos, high_pos;

    qsel_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .SW    (SW)
    ) u_store (
        .clk     (clk),
        .p_we    (p_we),
        .p_waddr (p_waddr),
        .p_wdata (p_wdata),
        .p_raddr (p_raddr),
        .p_q     (p_q),
        .c_we    (c_we),
        .c_waddr (c_waddr),
        .c_wdata (c_wdata),
        .c_raddr (c_raddr),
        .c_q     (c_q)
    );

    // The output word drains in the same cycle a new item may be taken, so
    // every path that later fills the output finds it empty.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign particle  = particle_reg;
    assign key       = key_reg;
    assign status    = status_reg;

    assign slot_ok  = 32'(slot) < MAX_PARTICLES;
    assign axis_ok  = (axis == qsel_pkg::AXIS_X) || (axis == qsel_pkg::AXIS_Y)
                   || (axis == qsel_pkg::AXIS_Z);
    assign sel_ok   = axis_ok && (32'(range_high) < MAX_PARTICLES)
                   && (rank >= range_low) && (rank <= range_high);

    assign rank_pos = $signed(PW'(rank));
    assign low_pos  = $signed(PW'(range_low));
    assign high_pos = $signed(PW'(range_high));
    assign i_inc    = i_reg + PW'(1);
    assign j_dec    = j_reg - PW'(1);

    // Key of the particle whose coordinates were read last cycle.
    always_comb
    begin
        unique case (axis_reg)
            qsel_pkg::AXIS_X: key_sel = $signed(c_q[SW-1:0]);
            qsel_pkg::AXIS_Y: key_sel = $signed(c_q[2*SW-1:SW]);
            default:          key_sel = $signed(c_q[3*SW-1:2*SW]);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        v_next         = v_reg;
        pk_next        = pk_reg;
        t_next         = t_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !out_ready;
        particle_next  = particle_reg;
        key_next       = key_reg;
        status_next    = status_reg;

        p_we    = 1'b0;
        p_waddr = i_reg[AW-1:0];
        p_wdata = t_reg;
        p_raddr = i_reg[AW-1:0];
        c_we    = 1'b0;
        c_waddr = slot[AW-1:0];
        c_wdata = {coord_z[SW-1:0], coord_y[SW-1:0], coord_x[SW-1:0]};
        c_raddr = p_q;

        unique case (state_reg)
            S_IDLE:
            begin
                p_raddr = slot[AW-1:0];
                if (accept)
                begin
                    axis_next     = axis;
                    particle_next = '0;
                    key_next      = '0;
                    status_next   = qsel_pkg::STATUS_OK;
                    priority if (op == qsel_pkg::OP_WRITE)
                    begin
                        out_valid_next = 1'b1;
                        if (slot_ok)
                        begin
                            c_we    = 1'b1;
                            p_we    = 1'b1;
                            p_waddr = slot[AW-1:0];
                            p_wdata = slot[AW-1:0];
                        end
                        else
                        begin
                            status_next = qsel_pkg::STATUS_ERR;
                        end
                    end
                    else if (op == qsel_pkg::OP_READ && slot_ok && axis_ok)
                    begin
                        state_next = S_RD1;
                    end
                    else if (op == qsel_pkg::OP_SELECT && sel_ok)
                    begin
                        k_next     = rank_pos;
                        l_next     = low_pos;
                        r_next     = high_pos;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        status_next    = qsel_pkg::STATUS_ERR;
                    end
                end
            end
            S_RD1:
            begin
                c_raddr    = p_q;
                pk_next    = p_q;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                out_valid_next = 1'b1;
                particle_next  = qsel_pkg::IDX_W'(pk_reg);
                key_next       = qsel_pkg::KEY_W'(key_sel);
                state_next     = S_IDLE;
            end
            S_OUT:
            begin
                p_raddr = k_reg[AW-1:0];
                if (r_reg > l_reg)
                begin
                    state_next = S_O1;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_O1:
            begin
                pk_next    = p_q;
                c_raddr    = p_q;
                p_raddr    = r_reg[AW-1:0];
                state_next = S_O2;
            end
            S_O2:
            begin
                v_next     = key_sel;
                t_next     = p_q;
                p_we       = 1'b1;
                p_waddr    = r_reg[AW-1:0];
                p_wdata    = pk_reg;
                state_next = S_O3;
            end
            S_O3:
            begin
                p_we       = 1'b1;
                p_waddr    = k_reg[AW-1:0];
                p_wdata    = t_reg;
                i_next     = l_reg - PW'(1);
                j_next     = r_reg;
                state_next = S_SI;
            end
            S_SI:
            begin
                p_raddr = i_inc[AW-1:0];
                if (i_reg < j_reg)
                begin
                    i_next     = i_inc;
                    state_next = S_SI1;
                end
                else
                begin
                    state_next = S_SJ;
                end
            end
            S_SI1:
            begin
                c_raddr    = p_q;
                state_next = S_SI2;
            end
            S_SI2:
            begin
                state_next = (key_sel >= v_reg) ? S_SJ : S_SI;
            end
            S_SJ:
            begin
                p_raddr = j_dec[AW-1:0];
                if (i_reg < j_reg)
                begin
                    j_next     = j_dec;
                    state_next = S_SJ1;
                end
                else
                begin
                    state_next = S_W0;
                end
            end
            S_SJ1:
            begin
                c_raddr    = p_q;
                state_next = S_SJ2;
            end
            S_SJ2:
            begin
                state_next = (key_sel <= v_reg) ? S_W0 : S_SJ;
            end
            S_W0:
            begin
                p_raddr    = i_reg[AW-1:0];
                state_next = S_W1;
            end
            S_W1:
            begin
                t_next     = p_q;
                p_raddr    = j_reg[AW-1:0];
                state_next = S_W2;
            end
            S_W2:
            begin
                p_we       = 1'b1;
                p_waddr    = i_reg[AW-1:0];
                p_wdata    = p_q;
                state_next = S_W3;
            end
            S_W3:
            begin
                p_we       = 1'b1;
                p_waddr    = j_reg[AW-1:0];
                p_wdata    = t_reg;
                state_next = (j_reg <= i_reg) ? S_F0 : S_SI;
            end
            S_F0:
            begin
                p_raddr    = i_reg[AW-1:0];
                state_next = S_F1;
            end
            S_F1:
            begin
                p_we       = 1'b1;
                p_waddr    = j_reg[AW-1:0];
                p_wdata    = p_q;
                state_next = S_F2;
            end
            S_F2:
            begin
                p_raddr    = r_reg[AW-1:0];
                state_next = S_F3;
            end
            S_F3:
            begin
                p_we       = 1'b1;
                p_waddr    = i_reg[AW-1:0];
                p_wdata    = p_q;
                state_next = S_F4;
            end
            S_F4:
            begin
                p_we    = 1'b1;
                p_waddr = r_reg[AW-1:0];
                p_wdata = t_reg;
                if (i_reg >= k_reg)
                begin
                    r_next = i_reg - PW'(1);
                end
                if (i_reg <= k_reg)
                begin
                    l_next = i_inc;
                end
                state_next = S_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        v_reg        <= v_next;
        pk_reg       <= pk_next;
        t_reg        <= t_next;
        axis_reg     <= axis_next;
        particle_reg <= particle_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
    end

    // Input is taken only by the idle sequencer.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("input taken while sequencer busy");

    // While an item is in work the output word is empty.
    a_out_empty_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !out_valid_reg)
        else $error("output word full during work");

    // The forward scan never passes the backward scan.
    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SI || state_reg == S_SJ) |-> i_reg <= j_reg)
        else $error("scan positions crossed");

    // A pass that narrows the range always shrinks it.
    a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_F4 |=> (r_reg - l_reg) < ($past(r_reg) - $past(l_reg)))
        else $error("select range did not shrink");

endmodule
